// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the clocked checks used in the sequencer's modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/snfcs_pkg.sv =====
// ---------------------------------------------------------------------------
// SPI NOR command sequencer package
// Item types, command bytes, codes and flash geometry shared by the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package snfcs_pkg;

  localparam int SUBSECTOR_BYTES  = 4096;
  localparam int PAGE_BYTES       = 256;
  localparam int READ_CHUNK_BYTES = 65536;

  localparam logic [31:0] SUBSECTOR_MASK = 32'(SUBSECTOR_BYTES - 1);
  localparam logic [31:0] PAGE_MASK      = 32'(PAGE_BYTES - 1);

  localparam logic [1:0] MODE_READ     = 2'd0;
  localparam logic [1:0] MODE_PROGRAM  = 2'd1;
  localparam logic [1:0] MODE_ERASE    = 2'd2;
  localparam logic [1:0] MODE_RESPONSE = 2'd3;

  localparam logic [7:0] OP_NONE = 8'h00;
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_SSE  = 8'h20;
  localparam logic [7:0] OP_READ = 8'h03;

  localparam int SR_WIP_BIT = 0;
  localparam int SR_WEL_BIT = 1;

  localparam logic [2:0] ADDR_BYTES_NONE = 3'd0;
  localparam logic [2:0] ADDR_BYTES_3    = 3'd3;
  localparam logic [2:0] ADDR_BYTES_4    = 3'd4;

  localparam logic [2:0] OUTCOME_OK          = 3'd0;
  localparam logic [2:0] OUTCOME_BAD_ERASE   = 3'd1;
  localparam logic [2:0] OUTCOME_XFER_FAILED = 3'd2;
  localparam logic [2:0] OUTCOME_NO_WEL      = 3'd3;
  localparam logic [2:0] OUTCOME_POLL_LIMIT  = 3'd4;

  localparam logic [1:0] REG_ADDRESS_MODE = 2'd0;
  localparam logic [1:0] REG_SELECT_LINE  = 2'd1;
  localparam logic [1:0] REG_POLL_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] length;
    logic [7:0]  status_byte;
    logic        transfer_failed;
  } request_t;

  typedef struct packed {
    logic        is_done;
    logic [7:0]  opcode;
    logic [2:0]  address_bytes;
    logic [31:0] command_address;
    logic [8:0]  write_count;
    logic [16:0] read_count;
    logic [31:0] buffer_offset;
    logic [2:0]  outcome;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/spi_nor_flash_command_sequencer.sv =====
// ---------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns read, program and erase requests into flash command descriptors.
// ---------------------------------------------------------------------------
// Requests and command responses arrive on one input channel (item_valid,
// item_stall); mode selects which it is. Each accepted request gives a first
// descriptor or an immediate completion; each response to the last descriptor
// gives the next descriptor or the completion. Items that arrive at the wrong
// time are dropped without a result.
// An accepted item is held in an input register and processed once the output
// register can take its result, which that register then presents. One item
// can be taken in every cycle while result_stall is low; the single-step
// state update sets that rate. When the receiver asserts result_stall the
// output register holds its item; the input register still takes one more
// item if it is empty, after which item_stall rises. Configuration is
// written through config_write, config_index and config_data; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears both registers' valid flags and the sequencer state, selects
// three-byte addressing and sets the poll limit to its maximum.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spi_nor_flash_command_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        config_write,
  input  wire logic [1:0]  config_index,
  input  wire logic [15:0] config_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] address,
  input  wire logic [31:0] length,
  input  wire logic [7:0]  status_byte,
  input  wire logic        transfer_failed,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             is_done,
  output logic [7:0]       opcode,
  output logic [2:0]       address_bytes,
  output logic [31:0]      command_address,
  output logic [8:0]       write_count,
  output logic [16:0]      read_count,
  output logic [31:0]      buffer_offset,
  output logic [2:0]       outcome
);

  import snfcs_pkg::*;

  logic        address_mode;
  logic [15:0] poll_limit;
  logic        in_valid;
  request_t    in_item;
  result_t     out_item;
  logic        advance;
  logic        has_result;
  result_t     core_result;

  assign advance    = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !advance;

  snfcs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .req          (in_item),
    .address_mode (address_mode),
    .poll_limit   (poll_limit),
    .has_result   (has_result),
    .result       (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      result_valid <= 1'b0;
      address_mode <= 1'b0;
      poll_limit   <= 16'hFFFF;
    end else begin
      if (item_valid && !item_stall) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= has_result;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      // The chip select takes no part in any result, so its writes are dropped.
      if (config_write) begin
        if (config_index == REG_ADDRESS_MODE) begin
          address_mode <= config_data[0];
        end else if (config_index == REG_POLL_LIMIT) begin
          poll_limit <= config_data;
        end
      end
    end
    if (item_valid && !item_stall) begin
      in_item.mode            <= mode;
      in_item.address         <= address;
      in_item.length          <= length;
      in_item.status_byte     <= status_byte;
      in_item.transfer_failed <= transfer_failed;
    end
    if (advance && has_result) begin
      out_item <= core_result;
    end
  end

  assign is_done         = out_item.is_done;
  assign opcode          = out_item.opcode;
  assign address_bytes   = out_item.address_bytes;
  assign command_address = out_item.command_address;
  assign write_count     = out_item.write_count;
  assign read_count      = out_item.read_count;
  assign buffer_offset   = out_item.buffer_offset;
  assign outcome         = out_item.outcome;

  `ASSERT_IMPLIES(a_stall_needs_held_item, clk, rst, item_stall, in_valid && result_valid && result_stall, "Input stalled without a held item behind a stalled result.")
  `ASSERT_IMPLIES(a_short_address, clk, rst, result_valid && address_bytes == ADDR_BYTES_3, command_address[31:24] == 8'h00, "Three-byte command carries a high address byte.")
  `ASSERT_IMPLIES(a_done_is_bare, clk, rst, result_valid && is_done, opcode == OP_NONE && address_bytes == ADDR_BYTES_NONE && buffer_offset == 32'd0, "Completion item carries command fields.")
  `ASSERT_IMPLIES(a_descriptor_ok, clk, rst, result_valid && !is_done, outcome == OUTCOME_OK && opcode != OP_NONE, "Descriptor item carries an outcome or no opcode.")

endmodule

`default_nettype wire

// ===== hdl/snfcs_core.sv =====
// ---------------------------------------------------------------------------
// SPI NOR command sequencer core
// Holds the request state and works out the next descriptor or completion
// for one registered item in a single step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module snfcs_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire snfcs_pkg::request_t req,
  input  wire logic              address_mode,
  input  wire logic [15:0]       poll_limit,
  output logic                   has_result,
  output snfcs_pkg::result_t     result
);

  import snfcs_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_READ,
    PH_WREN,
    PH_WEL,
    PH_OP,
    PH_POLL
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  operation, operation_next;
  logic [31:0] current_address, current_address_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] data_offset, data_offset_next;
  logic [16:0] chunk_bytes, chunk_bytes_next;
  logic [15:0] poll_count, poll_count_next;

  logic [31:0] chunk_address, chunk_offset, chunk_left;
  logic [31:0] sub_address, sub_left;
  logic [16:0] first_read, next_read;
  logic [31:0] page_room, page_bytes;
  logic [15:0] poll_inc;

  function automatic result_t descriptor(input logic [7:0] op, input logic addressed,
                                         input logic four_bytes, input logic [31:0] addr,
                                         input logic [8:0] wc, input logic [16:0] rc,
                                         input logic [31:0] off);
    result_t r;
    r = '0;
    r.opcode = op;
    if (addressed) begin
      r.address_bytes = four_bytes ? ADDR_BYTES_4 : ADDR_BYTES_3;
      r.command_address = four_bytes ? addr : {8'h00, addr[23:0]};
    end
    r.write_count = wc;
    r.read_count = rc;
    r.buffer_offset = off;
    return r;
  endfunction

  function automatic result_t completion(input logic [2:0] code);
    result_t r;
    r = '0;
    r.is_done = 1'b1;
    r.outcome = code;
    return r;
  endfunction

  assign chunk_address = current_address + 32'(chunk_bytes);
  assign chunk_offset  = data_offset + 32'(chunk_bytes);
  assign chunk_left    = bytes_left - 32'(chunk_bytes);
  assign sub_address   = current_address + 32'(SUBSECTOR_BYTES);
  assign sub_left      = bytes_left - 32'(SUBSECTOR_BYTES);
  assign first_read    = (req.length < 32'(READ_CHUNK_BYTES)) ? req.length[16:0]
                                                               : 17'(READ_CHUNK_BYTES);
  assign next_read     = (chunk_left < 32'(READ_CHUNK_BYTES)) ? chunk_left[16:0]
                                                               : 17'(READ_CHUNK_BYTES);
  assign page_room     = 32'(PAGE_BYTES) - (current_address & PAGE_MASK);
  assign page_bytes    = (bytes_left < page_room) ? bytes_left : page_room;
  assign poll_inc      = (poll_count != 16'hFFFF) ? poll_count + 16'd1 : poll_count;

  always_comb begin
    phase_next           = phase;
    operation_next       = operation;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    data_offset_next     = data_offset;
    chunk_bytes_next     = chunk_bytes;
    poll_count_next      = poll_count;
    has_result           = 1'b0;
    result               = '0;
    if (req.mode != MODE_RESPONSE) begin
      if (phase == PH_IDLE) begin
        has_result           = 1'b1;
        operation_next       = req.mode;
        current_address_next = req.address;
        bytes_left_next      = req.length;
        data_offset_next     = '0;
        chunk_bytes_next     = '0;
        poll_count_next      = '0;
        if (req.mode == MODE_ERASE && (req.length & SUBSECTOR_MASK) != 32'd0) begin
          result = completion(OUTCOME_BAD_ERASE);
        end else if (req.length == 32'd0) begin
          result = completion(OUTCOME_OK);
        end else if (req.mode == MODE_READ) begin
          phase_next       = PH_READ;
          chunk_bytes_next = first_read;
          result = descriptor(OP_READ, 1'b1, address_mode, req.address, 9'd0,
                              first_read, 32'd0);
        end else begin
          phase_next = PH_WREN;
          result = descriptor(OP_WREN, 1'b0, address_mode, 32'd0, 9'd0, 17'd0, 32'd0);
        end
      end
    end else if (phase != PH_IDLE) begin
      has_result = 1'b1;
      if (req.transfer_failed) begin
        phase_next = PH_IDLE;
        result = completion(OUTCOME_XFER_FAILED);
      end else begin
        unique case (phase)
          PH_READ: begin
            current_address_next = chunk_address;
            data_offset_next     = chunk_offset;
            bytes_left_next      = chunk_left;
            if (chunk_left == 32'd0) begin
              phase_next = PH_IDLE;
              result = completion(OUTCOME_OK);
            end else begin
              chunk_bytes_next = next_read;
              result = descriptor(OP_READ, 1'b1, address_mode, chunk_address, 9'd0,
                                  next_read, chunk_offset);
            end
          end
          PH_WREN: begin
            phase_next = PH_WEL;
            result = descriptor(OP_RDSR, 1'b0, address_mode, 32'd0, 9'd0, 17'd1, 32'd0);
          end
          PH_WEL: begin
            if (!req.status_byte[SR_WEL_BIT]) begin
              phase_next = PH_IDLE;
              result = completion(OUTCOME_NO_WEL);
            end else begin
              phase_next      = PH_OP;
              poll_count_next = '0;
              if (operation == MODE_PROGRAM) begin
                chunk_bytes_next = page_bytes[16:0];
                result = descriptor(OP_PP, 1'b1, address_mode, current_address,
                                    page_bytes[8:0], 17'd0, data_offset);
              end else begin
                chunk_bytes_next = '0;
                result = descriptor(OP_SSE, 1'b1, address_mode, current_address, 9'd0,
                                    17'd0, 32'd0);
              end
            end
          end
          PH_OP: begin
            phase_next = PH_POLL;
            result = descriptor(OP_RDSR, 1'b0, address_mode, 32'd0, 9'd0, 17'd1, 32'd0);
          end
          PH_POLL: begin
            if (req.status_byte[SR_WIP_BIT]) begin
              poll_count_next = poll_inc;
              if (poll_inc >= poll_limit) begin
                phase_next = PH_IDLE;
                result = completion(OUTCOME_POLL_LIMIT);
              end else begin
                result = descriptor(OP_RDSR, 1'b0, address_mode, 32'd0, 9'd0, 17'd1,
                                    32'd0);
              end
            end else begin
              if (operation == MODE_PROGRAM) begin
                current_address_next = chunk_address;
                data_offset_next     = chunk_offset;
                bytes_left_next      = chunk_left;
              end else begin
                current_address_next = sub_address;
                bytes_left_next      = sub_left;
              end
              if (bytes_left_next == 32'd0) begin
                phase_next = PH_IDLE;
                result = completion(OUTCOME_OK);
              end else begin
                phase_next = PH_WREN;
                result = descriptor(OP_WREN, 1'b0, address_mode, 32'd0, 9'd0, 17'd0,
                                    32'd0);
              end
            end
          end
          default: begin
            has_result = 1'b0;
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      operation       <= '0;
      current_address <= '0;
      bytes_left      <= '0;
      data_offset     <= '0;
      chunk_bytes     <= '0;
      poll_count      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      operation       <= operation_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      data_offset     <= data_offset_next;
      chunk_bytes     <= chunk_bytes_next;
      poll_count      <= poll_count_next;
    end
  end

  `ASSERT_NEXT(a_done_goes_idle, clk, rst, step && has_result && result.is_done, phase == PH_IDLE, "A completion did not return the sequencer to idle.")
  `ASSERT_IMPLIES(a_idle_response_dropped, clk, rst, step && phase == PH_IDLE && req.mode == MODE_RESPONSE, !has_result, "A response while idle produced a result.")
  `ASSERT_IMPLIES(a_busy_request_dropped, clk, rst, step && phase != PH_IDLE && req.mode != MODE_RESPONSE, !has_result, "A request while busy produced a result.")

endmodule

`default_nettype wire
